// ===== rtl/ppi_pkg.sv =====
package ppi_pkg;

   typedef enum logic {
      FUNC_READ  = 1'b0,
      FUNC_WRITE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ADDR_PORT_A  = 2'd0,
      ADDR_PORT_B  = 2'd1,
      ADDR_PORT_C  = 2'd2,
      ADDR_CONTROL = 2'd3
   } addr_type;

   localparam logic [7:0] CW_RESET    = 8'h9b;
   localparam int         CW_MODE_SET = 7;

   localparam logic [7:0] MASK_ALL      = 8'hff;
   localparam logic [7:0] MASK_NONE     = 8'h00;
   localparam logic [7:0] MASK_C_UPPER  = 8'hf0;
   localparam logic [7:0] MASK_C_LOWER  = 8'h0f;
   localparam logic [7:0] MASK_C_AMODE1 = 8'hc7;
   localparam logic [7:0] MASK_C_AMODE2 = 8'h07;
   localparam logic [7:0] MASK_C_BMODE1 = 8'hf8;

   typedef struct packed {
      func_type   func;
      addr_type   addr;
      logic [7:0] wdata;
      logic [7:0] pins_a;
      logic [7:0] pins_b;
      logic [7:0] pins_c;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] drive_a;
      logic [7:0] drive_b;
      logic [7:0] drive_c;
      logic [7:0] enable_a;
      logic [7:0] enable_b;
      logic [7:0] enable_c;
      logic [2:0] ports_updated;
   } result_type;

   typedef struct packed {
      logic [7:0] in_a;
      logic [7:0] in_b;
      logic [7:0] in_c;
      logic [7:0] out_a;
      logic [7:0] out_b;
      logic [7:0] out_c;
   } mask_type;

   // Decode direction and mode bits of a control word into pin masks.
   function automatic mask_type masks_of(input logic [7:0] cw);
      mask_type   m;
      logic [1:0] amode;
      logic       bmode;
      amode = cw[6:5];
      bmode = cw[2];
      if (amode == 2'd3) amode = 2'd2;

      if (amode == 2'd2) begin
         m.in_a  = MASK_ALL;
         m.out_a = MASK_ALL;
      end else if (cw[4]) begin
         m.in_a  = MASK_ALL;
         m.out_a = MASK_NONE;
      end else begin
         m.in_a  = MASK_NONE;
         m.out_a = MASK_ALL;
      end

      if (cw[1]) begin
         m.in_b  = MASK_ALL;
         m.out_b = MASK_NONE;
      end else begin
         m.in_b  = MASK_NONE;
         m.out_b = MASK_ALL;
      end

      m.in_c  = (cw[3] ? MASK_C_UPPER : MASK_NONE) | (cw[0] ? MASK_C_LOWER : MASK_NONE);
      m.out_c = (cw[3] ? MASK_NONE : MASK_C_UPPER) | (cw[0] ? MASK_NONE : MASK_C_LOWER);

      // reserve handshake lines of port C
      if (amode == 2'd1) begin
         m.in_c  = m.in_c & MASK_C_AMODE1;
         m.out_c = m.out_c & MASK_C_AMODE1;
      end else if (amode == 2'd2) begin
         m.in_c  = m.in_c & MASK_C_AMODE2;
         m.out_c = m.out_c & MASK_C_AMODE2;
      end
      if (bmode) begin
         m.in_c  = m.in_c & MASK_C_BMODE1;
         m.out_c = m.out_c & MASK_C_BMODE1;
      end
      return m;
   endfunction

endpackage

// ===== rtl/ppi_core.sv =====
module ppi_core import ppi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   output result_type result
);

   logic [7:0] cw_ff, cw_in;
   logic [7:0] latch_a_ff, latch_b_ff, latch_c_ff;
   logic [7:0] latch_a_in, latch_b_in, latch_c_in;
   logic [7:0] output_a_ff, output_b_ff, output_c_ff;
   logic [7:0] output_a_in, output_b_in, output_c_in;
   mask_type   cur_m;
   mask_type   new_m;
   mask_type   res_m;
   logic [7:0] bit_m;
   logic [7:0] rd;
   logic [2:0] upd;

   assign cur_m = masks_of(cw_ff);
   assign new_m = masks_of(item.wdata);
   assign bit_m = 8'(1) << item.wdata[3:1];

   always_comb begin
      cw_in       = cw_ff;
      latch_a_in  = latch_a_ff;
      latch_b_in  = latch_b_ff;
      latch_c_in  = latch_c_ff;
      output_a_in = output_a_ff;
      output_b_in = output_b_ff;
      output_c_in = output_c_ff;
      res_m       = cur_m;
      rd          = 8'h00;
      upd         = 3'b000;

      if (item.func == FUNC_READ) begin
         unique case (item.addr)
            ADDR_PORT_A:  rd = (item.pins_a & cur_m.in_a) | (output_a_ff & cur_m.out_a);
            ADDR_PORT_B:  rd = (item.pins_b & cur_m.in_b) | (output_b_ff & cur_m.out_b);
            ADDR_PORT_C:  rd = (item.pins_c & cur_m.in_c) | (output_c_ff & cur_m.out_c);
            ADDR_CONTROL: rd = cw_ff;
            default:      rd = 8'h00;
         endcase
      end else begin
         unique case (item.addr)
            ADDR_PORT_A: begin
               latch_a_in  = item.wdata;
               output_a_in = (output_a_ff & ~cur_m.out_a) | (item.wdata & cur_m.out_a);
               upd         = 3'b001;
            end
            ADDR_PORT_B: begin
               latch_b_in  = item.wdata;
               output_b_in = (output_b_ff & ~cur_m.out_b) | (item.wdata & cur_m.out_b);
               upd         = 3'b010;
            end
            ADDR_PORT_C: begin
               latch_c_in  = item.wdata;
               output_c_in = (output_c_ff & ~cur_m.out_c) | (item.wdata & cur_m.out_c);
               upd         = 3'b100;
            end
            ADDR_CONTROL: begin
               if (item.wdata[CW_MODE_SET]) begin
                  // mode set: clear every latch and driven value
                  cw_in       = item.wdata;
                  res_m       = new_m;
                  latch_a_in  = 8'h00;
                  latch_b_in  = 8'h00;
                  latch_c_in  = 8'h00;
                  output_a_in = 8'h00;
                  output_b_in = 8'h00;
                  output_c_in = 8'h00;
                  upd         = 3'b111;
               end else begin
                  // single bit set/reset on port C
                  latch_c_in  = item.wdata[0] ? (latch_c_ff | bit_m) : (latch_c_ff & ~bit_m);
                  output_c_in = (output_c_ff & ~cur_m.out_c) | (latch_c_in & cur_m.out_c);
                  upd         = 3'b100;
               end
            end
            default: upd = 3'b000;
         endcase
      end
   end

   assign result.read_data     = rd;
   assign result.drive_a       = output_a_in;
   assign result.drive_b       = output_b_in;
   assign result.drive_c       = output_c_in;
   assign result.enable_a      = res_m.out_a;
   assign result.enable_b      = res_m.out_b;
   assign result.enable_c      = res_m.out_c;
   assign result.ports_updated = upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff       <= CW_RESET;
         latch_a_ff  <= 8'h00;
         latch_b_ff  <= 8'h00;
         latch_c_ff  <= 8'h00;
         output_a_ff <= 8'h00;
         output_b_ff <= 8'h00;
         output_c_ff <= 8'h00;
      end else if (fire) begin
         cw_ff       <= cw_in;
         latch_a_ff  <= latch_a_in;
         latch_b_ff  <= latch_b_in;
         latch_c_ff  <= latch_c_in;
         output_a_ff <= output_a_in;
         output_b_ff <= output_b_in;
         output_c_ff <= output_c_in;
      end
   end

`ifndef SYNTHESIS
   a_mode_set_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.func == FUNC_WRITE && item.addr == ADDR_CONTROL && item.wdata[CW_MODE_SET]
      |=> output_a_ff == 8'h00 && output_b_ff == 8'h00 && output_c_ff == 8'h00
          && latch_c_ff == 8'h00)
      else $error("mode set left a latch or output nonzero");

   a_read_keeps_state: assert property (@(posedge clock) disable iff (reset)
      fire && item.func == FUNC_READ
      |=> $stable(cw_ff) && $stable(latch_a_ff) && $stable(latch_b_ff) && $stable(latch_c_ff)
          && $stable(output_a_ff) && $stable(output_b_ff) && $stable(output_c_ff))
      else $error("read changed device state");

   a_undriven_c_held: assert property (@(posedge clock) disable iff (reset)
      fire && !(item.func == FUNC_WRITE && item.addr == ADDR_CONTROL && item.wdata[CW_MODE_SET])
      |=> (output_c_ff & ~cur_m.out_c) == $past(output_c_ff & ~cur_m.out_c))
      else $error("port C bit outside output mask changed");
`endif

endmodule

// ===== rtl/parallel_port_interface_8255.sv =====
// Path: input register, then result register once that one is free or taken.
// Throughput: one word per cycle while rsp_ready is high; the result
// register frees itself while a held result is taken, so both sides may
// stream back to back.
// Reset: synchronous; control word returns to 9Bh (mode 0, all inputs),
// latches and driven values clear, both pipeline stages empty.
module parallel_port_interface_8255 import ppi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [1:0] req_addr,
   input  logic [7:0] req_wdata,
   input  logic [7:0] req_pins_a,
   input  logic [7:0] req_pins_b,
   input  logic [7:0] req_pins_c,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic [7:0] rsp_drive_a,
   output logic [7:0] rsp_drive_b,
   output logic [7:0] rsp_drive_c,
   output logic [7:0] rsp_enable_a,
   output logic [7:0] rsp_enable_b,
   output logic [7:0] rsp_enable_c,
   output logic [2:0] rsp_ports_updated
);

   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   item_type   item_ff;
   result_type result_ff;
   result_type result;
   logic       load_out;
   logic       advance;
   logic       req_fire;

   assign load_out  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && load_out;
   assign req_ready = !in_valid_ff || load_out;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.func   <= func_type'(req_func);
         item_ff.addr   <= addr_type'(req_addr);
         item_ff.wdata  <= req_wdata;
         item_ff.pins_a <= req_pins_a;
         item_ff.pins_b <= req_pins_b;
         item_ff.pins_c <= req_pins_c;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   ppi_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .result (result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_data     = result_ff.read_data;
   assign rsp_drive_a       = result_ff.drive_a;
   assign rsp_drive_b       = result_ff.drive_b;
   assign rsp_drive_c       = result_ff.drive_c;
   assign rsp_enable_a      = result_ff.enable_a;
   assign rsp_enable_b      = result_ff.enable_b;
   assign rsp_enable_c      = result_ff.enable_c;
   assign rsp_ports_updated = result_ff.ports_updated;

`ifndef SYNTHESIS
   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced word did not reach result register");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(item_ff))
      else $error("pending input word lost");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !advance)
      else $error("result register overwritten while held");
`endif

endmodule
